// ===== rtl/lcpa_pkg.sv =====
// Shared types, constants and the clamp helper of the checkpoint page allocator.
`timescale 1ns / 1ps
package lcpa_pkg;

  localparam int unsigned PageLimit   = 64;
  localparam int unsigned MaxLanesDef = 64;
  localparam int unsigned PageW       = 6;
  localparam int unsigned CountW      = 7;
  localparam int unsigned LaneW       = 7;
  localparam int unsigned ActW        = 2;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 7;

  typedef enum logic [ActW-1:0] {
    ActAcquire = 2'd0,
    ActRelease = 2'd1,
    ActQuery   = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    StsGranted  = 3'd0,
    StsHeld     = 3'd1,
    StsNoneFree = 3'd2,
    StsBadReq   = 3'd3,
    StsReleased = 3'd4,
    StsRelNoop  = 3'd5,
    StsQueried  = 3'd6
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLaneCount = 1'd0,
    CfgCapacity  = 1'd1
  } cfg_idx_e;

  typedef enum logic {
    CtrlIdle = 1'b0,
    CtrlExec = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic             rd;
    logic             pop;
    logic             push;
    logic [PageW-1:0] push_page;
  } stk_cmd_t;

  typedef struct packed {
    logic [CountW-1:0] top;
    logic [PageW-1:0]  top_page;
  } stk_stat_t;

  typedef struct packed {
    logic             rd;
    logic             set;
    logic             clr;
    logic [PageW-1:0] page;
  } lt_cmd_t;

  function automatic logic [CountW-1:0] clamp_count(logic [CountW-1:0] val,
                                                     logic [CountW-1:0] lim);
    logic [CountW-1:0] res;
    res = val;
    if (res == '0) res = CountW'(1);
    if (res > lim) res = lim;
    return res;
  endfunction

endpackage

// ===== rtl/lcpa_free_stack.sv =====
// Free page stack: synchronous memory, top pointer and refill watermark.
`timescale 1ns / 1ps
module lcpa_free_stack import lcpa_pkg::*; #(
  parameter int unsigned RESET_CAP = PageLimit
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stk_cmd_t          cmd_i,
  input  logic              refill_i,
  input  logic [CountW-1:0] refill_cap_i,
  output stk_stat_t         stat_o
);

  logic [PageW-1:0]  mem_q [PageLimit];
  logic [PageW-1:0]  rd_data_q;
  logic [CountW-1:0] top_q, top_d;
  logic [CountW-1:0] min_q, min_d;
  logic [CountW-1:0] cap_q, cap_d;
  logic [CountW-1:0] rd_idx;
  logic [PageW-1:0]  orig_page;

  assign rd_idx    = top_q - CountW'(1);
  assign orig_page = PageW'(cap_q - CountW'(1) - rd_idx);

  always_comb begin
    top_d = top_q;
    min_d = min_q;
    cap_d = cap_q;
    if (refill_i) begin
      top_d = refill_cap_i;
      min_d = refill_cap_i;
      cap_d = refill_cap_i;
    end else if (cmd_i.pop) begin
      top_d = rd_idx;
      if (rd_idx < min_q) min_d = rd_idx;
    end else if (cmd_i.push) begin
      top_d = top_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= CountW'(RESET_CAP);
      min_q <= CountW'(RESET_CAP);
      cap_q <= CountW'(RESET_CAP);
    end else begin
      top_q <= top_d;
      min_q <= min_d;
      cap_q <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_data_q <= mem_q[rd_idx[PageW-1:0]];
    if (cmd_i.push) mem_q[top_q[PageW-1:0]] <= cmd_i.push_page;
  end

  // entries below the watermark still hold their refill value
  assign stat_o.top      = top_q;
  assign stat_o.top_page = (rd_idx < min_q) ? orig_page : rd_data_q;

endmodule

// ===== rtl/lcpa_lane_table.sv =====
// Lane table: valid flags in flops and held page numbers in a synchronous memory.
`timescale 1ns / 1ps
module lcpa_lane_table import lcpa_pkg::*; #(
  parameter int unsigned LANE_AW = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lt_cmd_t            cmd_i,
  input  logic               clear_all_i,
  input  logic [LANE_AW-1:0] rd_lane_i,
  input  logic [LANE_AW-1:0] wr_lane_i,
  output logic               valid_o,
  output logic [PageW-1:0]   page_o
);

  localparam int unsigned LaneNum = 2 ** LANE_AW;

  logic [LaneNum-1:0] valid_q, valid_d;
  logic [PageW-1:0]   mem_q [LaneNum];
  logic [PageW-1:0]   rd_data_q;

  always_comb begin
    valid_d = valid_q;
    if (clear_all_i) begin
      valid_d = '0;
    end else if (cmd_i.set) begin
      valid_d[wr_lane_i] = 1'b1;
    end else if (cmd_i.clr) begin
      valid_d[wr_lane_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_data_q <= mem_q[rd_lane_i];
    if (cmd_i.set) mem_q[wr_lane_i] <= cmd_i.page;
  end

  assign valid_o = valid_q[wr_lane_i];
  assign page_o  = rd_data_q;

endmodule

// ===== rtl/lcpa_ctrl.sv =====
// Request sequencer: configuration, decision logic and result register.
`timescale 1ns / 1ps
module lcpa_ctrl import lcpa_pkg::*; #(
  parameter int unsigned LANE_DEPTH = PageLimit,
  parameter int unsigned LANE_AW    = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  logic [ActW-1:0]     req_action_i,
  input  logic [LaneW-1:0]    req_lane_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output logic [StatusW-1:0]  rsp_status_o,
  output logic [PageW-1:0]    rsp_page_o,
  output logic                rsp_held_o,
  output logic [CountW-1:0]   rsp_free_count_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output stk_cmd_t            stk_cmd_o,
  input  stk_stat_t           stk_stat_i,
  output logic                refill_o,
  output logic [CountW-1:0]   refill_cap_o,
  output lt_cmd_t             lt_cmd_o,
  output logic [LANE_AW-1:0]  rd_lane_o,
  output logic [LANE_AW-1:0]  wr_lane_o,
  input  logic                lt_valid_i,
  input  logic [PageW-1:0]    lt_page_i
);

  localparam logic [CountW-1:0] LaneLim = CountW'(LANE_DEPTH);

  ctrl_state_e       state_q, state_d;
  logic [CountW-1:0] lane_cnt_q, lane_cnt_d;
  logic [CountW-1:0] cap_q, cap_d;
  logic [CountW-1:0] eff_lanes_q, eff_lanes_d;
  logic [ActW-1:0]   act_q;
  logic [LaneW-1:0]  lane_q;
  logic              accept, commit, in_range, out_held;
  logic [StatusW-1:0] sts;
  logic [PageW-1:0]  out_page;
  logic [CountW-1:0] out_free;
  logic              pop, push, set, clr;

  logic                rsp_valid_q, rsp_valid_d;
  logic [StatusW-1:0]  rsp_status_q;
  logic [PageW-1:0]    rsp_page_q;
  logic                rsp_held_q;
  logic [CountW-1:0]   rsp_free_q;

  always_comb begin
    lane_cnt_d = lane_cnt_q;
    cap_d      = cap_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgLaneCount: lane_cnt_d = cfg_wdata_i;
        CfgCapacity:  cap_d      = cfg_wdata_i;
      endcase
    end
    eff_lanes_d = clamp_count(lane_cnt_d, LaneLim);
  end

  assign refill_o     = cfg_we_i;
  assign refill_cap_o = clamp_count(cap_d, eff_lanes_d);

  always_comb begin
    state_d = state_q;
    accept  = 1'b0;
    commit  = 1'b0;
    unique case (state_q)
      CtrlIdle: begin
        if (req_valid_i) begin
          accept  = 1'b1;
          state_d = CtrlExec;
        end
      end
      CtrlExec: begin
        if (!rsp_valid_q || !rsp_stall_i) begin
          commit  = 1'b1;
          state_d = CtrlIdle;
        end
      end
    endcase
  end

  assign req_stall_o = (state_q != CtrlIdle);

  assign in_range = (lane_q < eff_lanes_q);

  always_comb begin
    pop      = 1'b0;
    push     = 1'b0;
    set      = 1'b0;
    clr      = 1'b0;
    sts      = StsBadReq;
    out_held = in_range && lt_valid_i;
    out_page = out_held ? lt_page_i : '0;
    out_free = stk_stat_i.top;
    unique case (action_e'(act_q))
      ActAcquire: begin
        if (!in_range) begin
          sts = StsBadReq;
        end else if (lt_valid_i) begin
          sts = StsHeld;
        end else if (stk_stat_i.top == '0) begin
          sts = StsNoneFree;
        end else begin
          pop      = 1'b1;
          set      = 1'b1;
          sts      = StsGranted;
          out_held = 1'b1;
          out_page = stk_stat_i.top_page;
          out_free = stk_stat_i.top - CountW'(1);
        end
      end
      ActRelease: begin
        if (in_range && lt_valid_i && (stk_stat_i.top < CountW'(PageLimit))) begin
          push     = 1'b1;
          clr      = 1'b1;
          sts      = StsReleased;
          out_held = 1'b0;
          out_page = '0;
          out_free = stk_stat_i.top + CountW'(1);
        end else begin
          sts = StsRelNoop;
        end
      end
      ActQuery: sts = StsQueried;
      default:  sts = StsBadReq;
    endcase
  end

  assign stk_cmd_o.rd        = accept;
  assign stk_cmd_o.pop       = commit && pop;
  assign stk_cmd_o.push      = commit && push;
  assign stk_cmd_o.push_page = lt_page_i;

  assign lt_cmd_o.rd   = accept;
  assign lt_cmd_o.set  = commit && set;
  assign lt_cmd_o.clr  = commit && clr;
  assign lt_cmd_o.page = stk_stat_i.top_page;

  assign rd_lane_o = req_lane_i[LANE_AW-1:0];
  assign wr_lane_o = lane_q[LANE_AW-1:0];

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && !rsp_stall_i) rsp_valid_d = 1'b0;
    if (commit) rsp_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CtrlIdle;
      lane_cnt_q  <= CountW'(MaxLanesDef);
      cap_q       <= CountW'(PageLimit);
      eff_lanes_q <= LaneLim;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lane_cnt_q  <= lane_cnt_d;
      cap_q       <= cap_d;
      eff_lanes_q <= eff_lanes_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= req_action_i;
      lane_q <= req_lane_i;
    end
    if (commit) begin
      rsp_status_q <= sts;
      rsp_page_q   <= out_page;
      rsp_held_q   <= out_held;
      rsp_free_q   <= out_free;
    end
  end

  assign rsp_valid_o      = rsp_valid_q;
  assign rsp_status_o     = rsp_status_q;
  assign rsp_page_o       = rsp_page_q;
  assign rsp_held_o       = rsp_held_q;
  assign rsp_free_count_o = rsp_free_q;

endmodule

// ===== rtl/lane_checkpoint_page_allocator.sv =====
// Top level of the per-lane checkpoint page allocator.
//
// Request channel: req_valid_i / req_stall_o with action (acquire, release,
// query) and lane. Response channel: rsp_valid_o / rsp_stall_i with status,
// page, held flag and the number of free pages after the request.
// Configuration: cfg_we_i writes cfg_wdata_i into lane_count (index 0) or
// capacity (index 1); any write clears all lanes and refills the free stack
// at once, so no clearing pass is needed.
// Timing: an accepted request has its response registered from the execute
// state when the response register is free. The stack memory and the lane page
// memory are read in the accept cycle and updated in the commit cycle, one
// request in flight at a time.
// The block takes a new request while the previous response still waits.
// While rsp_stall_i holds a full response register, the request in flight
// waits and req_stall_o stays high.
// Reset: lane_count and capacity return to 64 (clamped to MAX_LANES), all
// lanes hold nothing and the stack holds every page with page 0 on top.
`timescale 1ns / 1ps
module lane_checkpoint_page_allocator import lcpa_pkg::*; #(
  parameter int unsigned MAX_LANES = MaxLanesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  logic [ActW-1:0]     req_action_i,
  input  logic [LaneW-1:0]    req_lane_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output logic [StatusW-1:0]  rsp_status_o,
  output logic [PageW-1:0]    rsp_page_o,
  output logic                rsp_held_o,
  output logic [CountW-1:0]   rsp_free_count_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned LaneDepth = (MAX_LANES < PageLimit) ? MAX_LANES : PageLimit;
  localparam int unsigned LaneAw    = (LaneDepth > 1) ? $clog2(LaneDepth) : 1;

  stk_cmd_t          stk_cmd;
  stk_stat_t         stk_stat;
  lt_cmd_t           lt_cmd;
  logic              refill;
  logic [CountW-1:0] refill_cap;
  logic [LaneAw-1:0] rd_lane, wr_lane;
  logic              lt_valid;
  logic [PageW-1:0]  lt_page;

  lcpa_ctrl #(
    .LANE_DEPTH (LaneDepth),
    .LANE_AW    (LaneAw)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_valid_i),
    .req_stall_o      (req_stall_o),
    .req_action_i     (req_action_i),
    .req_lane_i       (req_lane_i),
    .rsp_valid_o      (rsp_valid_o),
    .rsp_stall_i      (rsp_stall_i),
    .rsp_status_o     (rsp_status_o),
    .rsp_page_o       (rsp_page_o),
    .rsp_held_o       (rsp_held_o),
    .rsp_free_count_o (rsp_free_count_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .stk_cmd_o        (stk_cmd),
    .stk_stat_i       (stk_stat),
    .refill_o         (refill),
    .refill_cap_o     (refill_cap),
    .lt_cmd_o         (lt_cmd),
    .rd_lane_o        (rd_lane),
    .wr_lane_o        (wr_lane),
    .lt_valid_i       (lt_valid),
    .lt_page_i        (lt_page)
  );

  lcpa_free_stack #(
    .RESET_CAP (LaneDepth)
  ) u_free_stack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (stk_cmd),
    .refill_i     (refill),
    .refill_cap_i (refill_cap),
    .stat_o       (stk_stat)
  );

  lcpa_lane_table #(
    .LANE_AW (LaneAw)
  ) u_lane_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (lt_cmd),
    .clear_all_i (refill),
    .rd_lane_i   (rd_lane),
    .wr_lane_i   (wr_lane),
    .valid_o     (lt_valid),
    .page_o      (lt_page)
  );

endmodule

// ===== rtl/lcpa_checker.sv =====
// Port-level assertions for the checkpoint page allocator, bound to the top level.
`timescale 1ns / 1ps
module lcpa_checker import lcpa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_stall_o,
  input logic                rsp_valid_o,
  input logic                rsp_stall_i,
  input logic [StatusW-1:0]  rsp_status_o,
  input logic [PageW-1:0]    rsp_page_o,
  input logic                rsp_held_o,
  input logic [CountW-1:0]   rsp_free_count_o
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && !req_stall_o) |=> req_stall_o)
    else $error("request accepted while another is in flight");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_free_count_o <= CountW'(PageLimit)))
    else $error("free count above page limit");

  a_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_held_o) |-> (rsp_page_o == '0))
    else $error("page reported for a lane that holds nothing");

  a_held_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |->
      ((rsp_status_o != StsGranted && rsp_status_o != StsHeld) || rsp_held_o) &&
      ((rsp_status_o != StsReleased) || !rsp_held_o))
    else $error("held flag disagrees with status");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_stall_i) |=>
      (rsp_valid_o && $stable(rsp_status_o) && $stable(rsp_page_o) &&
       $stable(rsp_held_o) && $stable(rsp_free_count_o)))
    else $error("stalled response changed");

endmodule

bind lane_checkpoint_page_allocator lcpa_checker u_lcpa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_valid_i),
  .req_stall_o      (req_stall_o),
  .rsp_valid_o      (rsp_valid_o),
  .rsp_stall_i      (rsp_stall_i),
  .rsp_status_o     (rsp_status_o),
  .rsp_page_o       (rsp_page_o),
  .rsp_held_o       (rsp_held_o),
  .rsp_free_count_o (rsp_free_count_o)
);
